// ----- rtl/selective_repeat_sender_window_core_assert.svh -----
// Assertion macros for the selective-repeat sender window core.
// Needs nothing else; the macros are empty when SYNTHESIS is defined.
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_CORE_ASSERT_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define SRSW_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define SRSW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SRSW_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define SRSW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ----- rtl/srsw_pkg.sv -----
// Shared types and constants of the selective-repeat sender window core.
// No dependencies.
`default_nettype none

package srsw_pkg;

  localparam int CMD_W      = 2;
  localparam int ACK_W      = 8;
  localparam int KIND_W     = 3;
  localparam int SEQ_W      = 5;
  localparam int PKT_W      = 16;
  localparam int WIN_W      = 5;
  localparam int TMO_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEND  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_ACK   = 2'd3;

  localparam logic [KIND_W-1:0] KIND_NONE        = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SEND        = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RESEND      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ACK_TAKEN   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ACK_IGNORED = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PACKETS = 2'd2;

  localparam logic [WIN_W-1:0] WINDOW_SIZE_RST   = 5'd10;
  localparam logic [TMO_W-1:0] TIMEOUT_LIMIT_RST = 8'd20;
  localparam logic [PKT_W-1:0] TOTAL_PACKETS_RST = 16'd113;

  localparam logic [TMO_W-1:0] COUNT_MAX = 8'hFF;

  // one slot of the window store
  typedef struct packed {
    logic             free;
    logic             ahead;
    logic             running;
    logic [TMO_W-1:0] count;
    logic [PKT_W-1:0] packet;
  } entry_t;

  // result waiting to go out
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq;
    logic [PKT_W-1:0]  packet;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/selective_repeat_sender_window_core.sv -----
// Selective-repeat ARQ sender window: slot store in one synchronous RAM plus control FSM.
// Depends on srsw_pkg and selective_repeat_sender_window_core_assert.svh.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  cfg      | cfg_we               | cfg_index, cfg_data
//  in       | in_valid / in_ready  | cmd, ack_seq
//  out      | out_valid / out_ready| kind, wire_seq, packet_index, base_slot, last
//
// One item at a time; the RAM has one read and one write port, and its read data is registered.
// An ack slides the base over every acked slot; an out-of-range ack goes straight to the result.
// The tick scans one slot timer per cycle, held while a full output register blocks an expiry.
// Reset and start clear the per-slot valid bits at once; no clearing pass.
// A full output register stalls the tick scan and the final result of each item.
`default_nettype none

`include "selective_repeat_sender_window_core_assert.svh"

module selective_repeat_sender_window_core #(
  parameter int SEQ_COUNT = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [srsw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srsw_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [srsw_pkg::CMD_W-1:0]        cmd,
  input  logic [srsw_pkg::ACK_W-1:0]        ack_seq,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [srsw_pkg::KIND_W-1:0]       kind,
  output logic [srsw_pkg::SEQ_W-1:0]        wire_seq,
  output logic [srsw_pkg::PKT_W-1:0]        packet_index,
  output logic [srsw_pkg::SEQ_W-1:0]        base_slot,
  output logic                              last
);

  localparam int SW   = $clog2(SEQ_COUNT);
  localparam int CNTW = $clog2(SEQ_COUNT + 1);
  localparam int CMPW = (SW + 1 > srsw_pkg::WIN_W) ? SW + 1 : srsw_pkg::WIN_W;
  localparam logic [SW-1:0] LAST_SLOT = SW'(SEQ_COUNT - 1);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_SEND_CHK = 7'b0000010,
    ST_TICK_CHK = 7'b0000100,
    ST_ACK_WR   = 7'b0001000,
    ST_SL_RD    = 7'b0010000,
    ST_SL_CHK   = 7'b0100000,
    ST_FIN      = 7'b1000000
  } state_t;

  // configuration
  logic [srsw_pkg::WIN_W-1:0] window_size;
  logic [srsw_pkg::TMO_W-1:0] timeout_limit;
  logic [srsw_pkg::PKT_W-1:0] total_packets;

  // control state
  state_t                     state, state_next;
  logic [SW-1:0]              idx, idx_next;
  logic [CNTW-1:0]            slide_cnt, slide_cnt_next;
  logic [SW-1:0]              ack_slot, ack_slot_next;
  logic [SW-1:0]              next_slot, next_slot_next;
  logic [SW-1:0]              window_base, window_base_next;
  logic [srsw_pkg::PKT_W-1:0] packets_sent, packets_sent_next;
  srsw_pkg::result_t          pend, pend_next;
  logic                       pend_v, pend_v_next;

  // slot store
  srsw_pkg::entry_t           mem [SEQ_COUNT];
  logic [SEQ_COUNT-1:0]       valid;
  srsw_pkg::entry_t           rd_q;
  logic                       valid_q;
  logic                       mem_re, mem_we, clear_all;
  logic [SW-1:0]              mem_ra, mem_wa;
  srsw_pkg::entry_t           mem_wd;
  srsw_pkg::entry_t           ent;

  // output side
  logic                       push, push_last, can_push;

  // scratch
  logic [SW:0]                span;
  logic                       in_window;
  logic                       ack_ok;
  logic [SW-1:0]              ack_slot_in;
  logic [srsw_pkg::TMO_W-1:0] cnt_inc;
  logic                       expire;
  logic                       advance;
  logic [SW-1:0]              next_slot_inc, base_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= srsw_pkg::WINDOW_SIZE_RST;
      timeout_limit <= srsw_pkg::TIMEOUT_LIMIT_RST;
      total_packets <= srsw_pkg::TOTAL_PACKETS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        srsw_pkg::CFG_WINDOW_SIZE:   window_size   <= cfg_data[srsw_pkg::WIN_W-1:0];
        srsw_pkg::CFG_TIMEOUT_LIMIT: timeout_limit <= cfg_data[srsw_pkg::TMO_W-1:0];
        srsw_pkg::CFG_TOTAL_PACKETS: total_packets <= cfg_data[srsw_pkg::PKT_W-1:0];
        default: ;
      endcase
    end
  end

  // RAM: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_q    <= mem[mem_ra];
      valid_q <= valid[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      valid <= '0;
    end else if (mem_we) begin
      valid[mem_wa] <= 1'b1;
    end
  end

  // unwritten slot reads as free and idle
  always_comb begin
    ent = rd_q;
    if (!valid_q) begin
      ent.free    = 1'b1;
      ent.ahead   = 1'b0;
      ent.running = 1'b0;
      ent.count   = '0;
    end
  end

  assign span = (next_slot >= window_base)
              ? ({1'b0, next_slot} - {1'b0, window_base})
              : ({1'b0, next_slot} + (SW + 1)'(SEQ_COUNT) - {1'b0, window_base});
  assign in_window     = CMPW'(span) < CMPW'(window_size);
  assign ack_ok        = (ack_seq != '0) && (ack_seq <= srsw_pkg::ACK_W'(SEQ_COUNT));
  assign ack_slot_in   = SW'(ack_seq - 8'd1);
  assign cnt_inc       = (ent.count == srsw_pkg::COUNT_MAX) ? ent.count : ent.count + 8'd1;
  assign expire        = ent.running && (cnt_inc > timeout_limit);
  assign can_push      = !out_valid || out_ready;
  assign advance       = !(expire && pend_v && !can_push);
  assign next_slot_inc = (next_slot == LAST_SLOT) ? '0 : next_slot + 1'b1;
  assign base_inc      = (window_base == LAST_SLOT) ? '0 : window_base + 1'b1;
  assign in_ready      = (state == ST_IDLE);

  always_comb begin
    state_next        = state;
    idx_next          = idx;
    slide_cnt_next    = slide_cnt;
    ack_slot_next     = ack_slot;
    next_slot_next    = next_slot;
    window_base_next  = window_base;
    packets_sent_next = packets_sent;
    pend_next         = pend;
    pend_v_next       = pend_v;
    mem_re            = 1'b0;
    mem_ra            = idx;
    mem_we            = 1'b0;
    mem_wa            = idx;
    mem_wd            = ent;
    clear_all         = 1'b0;
    push              = 1'b0;
    push_last         = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd)
            srsw_pkg::CMD_START: begin
              clear_all         = 1'b1;
              next_slot_next    = '0;
              window_base_next  = '0;
              packets_sent_next = '0;
              pend_next         = '{srsw_pkg::KIND_NONE, '0, '0};
              state_next        = ST_FIN;
            end
            srsw_pkg::CMD_SEND: begin
              mem_re     = 1'b1;
              mem_ra     = next_slot;
              state_next = ST_SEND_CHK;
            end
            srsw_pkg::CMD_TICK: begin
              mem_re      = 1'b1;
              mem_ra      = '0;
              idx_next    = '0;
              pend_next   = '{srsw_pkg::KIND_NONE, '0, '0};
              pend_v_next = 1'b0;
              state_next  = ST_TICK_CHK;
            end
            default: begin
              if (ack_ok) begin
                mem_re        = 1'b1;
                mem_ra        = ack_slot_in;
                ack_slot_next = ack_slot_in;
                pend_next     = '{srsw_pkg::KIND_ACK_TAKEN,
                                  ack_seq[srsw_pkg::SEQ_W-1:0], '0};
                state_next    = ST_ACK_WR;
              end else begin
                pend_next  = '{srsw_pkg::KIND_ACK_IGNORED, '0, '0};
                state_next = ST_FIN;
              end
            end
          endcase
        end
      end
      ST_SEND_CHK: begin
        if (in_window && ent.free && (packets_sent < total_packets)) begin
          mem_we            = 1'b1;
          mem_wa            = next_slot;
          mem_wd.free       = 1'b0;
          mem_wd.running    = 1'b1;
          mem_wd.count      = '0;
          mem_wd.packet     = packets_sent;
          next_slot_next    = next_slot_inc;
          packets_sent_next = packets_sent + 16'd1;
          pend_next         = '{srsw_pkg::KIND_SEND,
                                srsw_pkg::SEQ_W'((SW + 1)'(next_slot) + 1'b1), packets_sent};
        end else begin
          pend_next = '{srsw_pkg::KIND_NONE, '0, '0};
        end
        state_next = ST_FIN;
      end
      ST_TICK_CHK: begin
        if (advance) begin
          if (ent.running) begin
            mem_we       = 1'b1;
            mem_wa       = idx;
            mem_wd.count = expire ? '0 : cnt_inc;
          end
          if (expire) begin
            // earlier expiry goes out now; the newest one is held to carry last
            push        = pend_v;
            pend_next   = '{srsw_pkg::KIND_RESEND,
                            srsw_pkg::SEQ_W'((SW + 1)'(idx) + 1'b1), ent.packet};
            pend_v_next = 1'b1;
          end
          if (idx == LAST_SLOT) begin
            state_next = ST_FIN;
          end else begin
            idx_next = idx + 1'b1;
            mem_re   = 1'b1;
            mem_ra   = idx + 1'b1;
          end
        end
      end
      ST_ACK_WR: begin
        mem_we         = 1'b1;
        mem_wa         = ack_slot;
        mem_wd.free    = 1'b1;
        mem_wd.ahead   = !ent.free;
        mem_wd.running = 1'b0;
        mem_wd.count   = '0;
        slide_cnt_next = '0;
        state_next     = ST_SL_RD;
      end
      ST_SL_RD: begin
        mem_re     = 1'b1;
        mem_ra     = window_base;
        state_next = ST_SL_CHK;
      end
      ST_SL_CHK: begin
        // write the old base while reading the next one: never the same slot
        if (ent.ahead && (slide_cnt != CNTW'(SEQ_COUNT))) begin
          mem_we           = 1'b1;
          mem_wa           = window_base;
          mem_wd.ahead     = 1'b0;
          window_base_next = base_inc;
          slide_cnt_next   = slide_cnt + 1'b1;
          mem_re           = 1'b1;
          mem_ra           = base_inc;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (can_push) begin
          push       = 1'b1;
          push_last  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      next_slot    <= '0;
      window_base  <= '0;
      packets_sent <= '0;
      pend_v       <= 1'b0;
    end else begin
      state        <= state_next;
      next_slot    <= next_slot_next;
      window_base  <= window_base_next;
      packets_sent <= packets_sent_next;
      pend_v       <= pend_v_next;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    slide_cnt <= slide_cnt_next;
    ack_slot  <= ack_slot_next;
    pend      <= pend_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      kind         <= pend.kind;
      wire_seq     <= pend.seq;
      packet_index <= pend.packet;
      base_slot    <= srsw_pkg::SEQ_W'(window_base);
      last         <= push_last;
    end
  end

  `SRSW_ASSERT_IMP(a_ptr_range, clk, rst, 1'b1, (int'(window_base) < SEQ_COUNT) && (int'(next_slot) < SEQ_COUNT), "window pointer out of range")
  `SRSW_ASSERT_IMP(a_push_room, clk, rst, push, !out_valid || out_ready, "result transfer overwrites a pending result")
  `SRSW_ASSERT_NEXT(a_start_clears, clk, rst, in_valid && in_ready && (cmd == srsw_pkg::CMD_START), (valid == '0) && (window_base == '0) && (packets_sent == '0), "start did not clear the window")

endmodule

`default_nettype wire
